[hdl/wnf_pkg.sv]
// Shared types and constants of the width-one novelty filter.
// No dependencies; every other file imports this package.
package wnf_pkg;

	localparam int IDX_W   = 7;   // feature_index width
	localparam int VAL_W   = 12;  // feature_value width
	localparam int CFG_W   = 4;   // widest configuration register
	localparam int CFG_IDX_W = 1; // configuration register index width

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BOOLEAN_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE  = 1'b1;

	localparam logic [CFG_W-1:0] BITS_IN_USE_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_MARK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// one classified element, as held in the queue
	typedef struct packed {
		opcode_t           op;
		logic              hit;        // index lies inside the table
		logic              bool_mode;
		logic [IDX_W-1:0]  row;
		logic [VAL_W-1:0]  col;        // clamped column for value mode
		logic [VAL_W-1:0]  ones;       // bits to mark in the seen-as-one row
		logic [VAL_W-1:0]  zeros;      // bits to mark in the seen-as-zero row
		logic              last;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} head_t;

endpackage

[hdl/wnf_front.sv]
// Front part of the novelty filter: classifies incoming elements and queues them.
// Depends on wnf_pkg.
module wnf_front import wnf_pkg::*; #(
	parameter int NUM_FEATURES = 128,
	parameter int COLUMNS      = 256,
	parameter int MAX_BITS     = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  opcode_t          in_op,
	input  logic [IDX_W-1:0] in_index,
	input  logic [VAL_W-1:0] in_value,
	input  logic             in_last,
	input  logic             boolean_mode,
	input  logic [CFG_W-1:0] bits_in_use,
	output head_t            head,
	input  logic             pop
);

	work_t            cls;
	logic [CFG_W-1:0] nbits;
	logic [VAL_W:0]   mask_w;
	logic [VAL_W-1:0] mask;
	logic             push;

	work_t      q_mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_comb begin
		nbits  = (bits_in_use > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : bits_in_use;
		mask_w = ((VAL_W+1)'(1) << nbits) - (VAL_W+1)'(1);
		mask   = mask_w[VAL_W-1:0];

		cls.op        = in_op;
		cls.hit       = (32'(in_index) < NUM_FEATURES);
		cls.bool_mode = boolean_mode;
		cls.row       = in_index;
		cls.col       = ({1'b0, in_value} > (VAL_W+1)'(COLUMNS - 1)) ?
			VAL_W'(COLUMNS - 1) : in_value;
		cls.ones      = in_value & mask;
		cls.zeros     = ~in_value & mask;
		cls.last      = in_last;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wp_q] <= cls;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.work  = q_mem[rp_q];

endmodule

[hdl/wnf_back.sv]
// Back part of the novelty filter: seen-pair tables and their read-modify-write.
// Depends on wnf_pkg.
module wnf_back import wnf_pkg::*; #(
	parameter int NUM_FEATURES = 128,
	parameter int COLUMNS      = 256,
	parameter int MAX_BITS     = 12
) (
	input  logic  clk,
	input  logic  arst_n,
	input  head_t head,
	output logic  pop,
	output logic  res_valid,
	output logic  res_novel,
	input  logic  res_ready
);

	localparam int ROWS  = (NUM_FEATURES < (1 << IDX_W)) ? NUM_FEATURES : (1 << IDX_W);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W = $clog2(COLUMNS);

	typedef enum logic [1:0] {
		ST_FETCH = 2'b01,
		ST_APPLY = 2'b10
	} state_t;

	state_t state_q;

	logic [COLUMNS-1:0]    vmem [ROWS];
	logic [2*MAX_BITS-1:0] bmem [ROWS];
	logic [ROWS-1:0]       vvalid_q;
	logic [ROWS-1:0]       bvalid_q;
	logic [COLUMNS-1:0]    vrd_q;
	logic [2*MAX_BITS-1:0] brd_q;
	logic                  nsf_q;

	work_t                 w;
	logic [ROW_W-1:0]      addr;
	logic [COL_W-1:0]      col;
	logic [COLUMNS-1:0]    vrow;
	logic [COLUMNS-1:0]    vnew;
	logic [2*MAX_BITS-1:0] brow;
	logic [MAX_BITS-1:0]   b_one;
	logic [MAX_BITS-1:0]   b_zero;
	logic [MAX_BITS-1:0]   m_one;
	logic [MAX_BITS-1:0]   m_zero;
	logic                  touch;
	logic                  fresh;
	logic                  need_res;
	logic                  fire;
	logic                  rd_en;

	always_comb begin
		w      = head.work;
		addr   = w.row[ROW_W-1:0];
		col    = w.col[COL_W-1:0];
		vrow   = vvalid_q[addr] ? vrd_q : '0;
		brow   = bvalid_q[addr] ? brd_q : '0;
		vnew   = vrow | (COLUMNS'(1) << col);
		b_one  = brow[MAX_BITS-1:0];
		b_zero = brow[2*MAX_BITS-1:MAX_BITS];
		m_one  = w.ones[MAX_BITS-1:0];
		m_zero = w.zeros[MAX_BITS-1:0];
		touch  = ((w.op == OP_CHECK) || (w.op == OP_MARK)) && w.hit;
		if (w.bool_mode)
			fresh = touch && ((|(m_one & ~b_one)) || (|(m_zero & ~b_zero)));
		else
			fresh = touch && !vrow[col];
		need_res = (w.op == OP_CHECK) && w.last;
		fire     = (state_q == ST_APPLY) && (!need_res || res_ready);
		rd_en    = (state_q == ST_FETCH) && head.valid;
	end

	assign pop       = fire;
	assign res_valid = (state_q == ST_APPLY) && need_res;
	assign res_novel = nsf_q || fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FETCH;
			vvalid_q <= '0;
			bvalid_q <= '0;
			nsf_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_FETCH: begin
					if (head.valid)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (fire) begin
						state_q <= ST_FETCH;
						if (touch && w.bool_mode)
							bvalid_q[addr] <= 1'b1;
						if (touch && !w.bool_mode)
							vvalid_q[addr] <= 1'b1;
						case (w.op)
							OP_CHECK: nsf_q <= w.last ? 1'b0 : (nsf_q || fresh);
							OP_CLEAR: begin
								vvalid_q <= '0;
								bvalid_q <= '0;
								nsf_q    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_FETCH;
			endcase
		end
	end

	// table memories: registered read in fetch, write back in apply
	always_ff @(posedge clk) begin
		if (rd_en) begin
			vrd_q <= vmem[addr];
			brd_q <= bmem[addr];
		end
		if (fire && touch && !w.bool_mode)
			vmem[addr] <= vnew;
		if (fire && touch && w.bool_mode)
			bmem[addr] <= {b_zero | m_zero, b_one | m_one};
	end

endmodule

[hdl/width_one_novelty_filter.sv]
// Top level of the width-one novelty filter: ports, configuration registers, result register.
// Depends on wnf_pkg, wnf_front and wnf_back.
//
// The block tests feature-value pairs of a state against seen-pair tables and
// reports per state whether any pair was new. Send one element per beat on the
// input stream: tuser carries the opcode (check, mark only, clear, no-op), tlast
// marks the final element of a state. Only a check beat with tlast set returns a
// beat on the output stream, whose bit 0 is the novel flag. In the table unit
// each element passes a fetch state, which reads the table row of its feature
// index, then an apply state, which modifies and writes it back; clear and no-op
// beats pass through the same states, since clearing resets per-row valid flags
// in one step rather than walking the tables. There is no clearing pass after
// reset. A two-entry queue sits in front of the table unit and a result register
// behind it, so input beats are taken while a result waits. Write configuration
// only while the block is idle. Indexes at or above NUM_FEATURES are ignored but
// still end a state; in value mode values at or above COLUMNS fall into the top column.
module width_one_novelty_filter import wnf_pkg::*; #(
	parameter int NUM_FEATURES = 128,
	parameter int COLUMNS      = 256,
	parameter int MAX_BITS     = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // [6:0] feature_index, [18:7] feature_value
	input  logic                 s_axis_tlast,  // last_element
	input  logic [1:0]           s_axis_tuser,  // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [0] novel
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic             boolean_mode_q;
	logic [CFG_W-1:0] bits_in_use_q;
	head_t            head;
	logic             pop;
	logic             res_valid;
	logic             res_novel;
	logic             res_ready;
	logic             out_valid_q;
	logic             novel_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boolean_mode_q <= 1'b0;
			bits_in_use_q  <= BITS_IN_USE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BOOLEAN_MODE: boolean_mode_q <= cfg_data[0];
				CFG_BITS_IN_USE:  bits_in_use_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	wnf_front #(
		.NUM_FEATURES(NUM_FEATURES),
		.COLUMNS     (COLUMNS),
		.MAX_BITS    (MAX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (opcode_t'(s_axis_tuser)),
		.in_index    (s_axis_tdata[IDX_W-1:0]),
		.in_value    (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
		.in_last     (s_axis_tlast),
		.boolean_mode(boolean_mode_q),
		.bits_in_use (bits_in_use_q),
		.head        (head),
		.pop         (pop)
	);

	wnf_back #(
		.NUM_FEATURES(NUM_FEATURES),
		.COLUMNS     (COLUMNS),
		.MAX_BITS    (MAX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.res_valid(res_valid),
		.res_novel(res_novel),
		.res_ready(res_ready)
	);

	// result register: take a new result whenever the slot is empty or draining
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			novel_q <= res_novel;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, novel_q};

endmodule
